// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the Forth stack machine core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent in a cycle implies the consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/fsmc_pkg.sv
// Shared types, codes and constants of the Forth stack machine core.
// Depends on nothing; used by the top level and the ALU of the core.
package fsmc_pkg;

    localparam int MEM_AW      = 16;
    localparam int STACK_AW    = 6;
    localparam int STACK_DEPTH = 63;
    localparam int CELL_W      = 64;
    localparam int CELL_BYTES  = 8;

    typedef logic [MEM_AW-1:0]   maddr_t;
    typedef logic [15:0]         pc_t;
    typedef logic [STACK_AW-1:0] sp_t;
    typedef logic [CELL_W-1:0]   cell_t;

    localparam sp_t SP_FULL = sp_t'(STACK_DEPTH);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_SETPC = 2'd2,
        REQ_EXEC  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_OPCODE = 2'd1,
        FAULT_DSTACK = 2'd2,
        FAULT_RSTACK = 2'd3
    } fault_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_XOR,
        ALU_AND,
        ALU_NOT,
        ALU_SHL,
        ALU_HALF
    } alu_op_t;

    typedef enum logic [4:0] {
        OP_JUMP, OP_RET, OP_JMPZ, OP_JMPL0, OP_CALL, OP_CSTA, OP_CFTA, OP_SYS,
        OP_LIT1, OP_FTAP, OP_LIT, OP_FTA, OP_STORE, OP_STAP, OP_FETCH, OP_STA,
        OP_COM, OP_SHL, OP_DIV2, OP_MUL, OP_XOR, OP_AND, OP_DEC, OP_ADD,
        OP_RFROM, OP_AREG, OP_DUP, OP_OVER, OP_TOR, OP_TOA, OP_INC, OP_DROP
    } op_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } req_t;

    typedef struct packed {
        logic [7:0]         rdata;
        logic [15:0]        pc_now;
        logic signed [63:0] top_of_stack;
        logic [5:0]         stack_depth;
        logic               halted;
        logic               sys_valid;
        logic signed [63:0] sys_code;
        fault_t             fault;
    } result_t;

    // Reduce any cell-sized address to the memory range, then to pc width.
    function automatic pc_t wrap_pc(input cell_t v);
        maddr_t m;
        m = maddr_t'(v);
        return pc_t'(m);
    endfunction

endpackage

// File: rtl/core/forth_stack_machine_core.sv
// Top level of the Forth stack machine core: sequencer, stacks and byte memory.
// Depends on fsmc_pkg, fsmc_ram, fsmc_alu and assert_macros.svh.
//
//  Channel   Ports                 Handshake
//  -------   -------------------   --------------------------------------
//  request   start, busy, req      taken at a clock edge with start & !busy
//  result    done, result          valid for the one cycle that done is high
//
// One request is worked on at a time; busy is high from the cycle after a
// request is taken until its result has been shown. An instruction fetches
// its opcode byte and reads the top cells of both stacks, then runs: stack
// and ALU operations finish in S_EXEC, cell loads and stores then walk the
// byte-serial memory port, and * runs 64 shift-add steps through the ALU.
// After reset the machine is halted with empty stacks.
// The receiver cannot stall, so done is a plain one-cycle strobe.
`include "assert_macros.svh"

module forth_stack_machine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fsmc_pkg::req_t     req,
    output logic               done,
    output fsmc_pkg::result_t  result
);

    typedef enum logic [4:0] {
        S_IDLE, S_MWR, S_BRQ, S_BRD, S_FETCH, S_FOP, S_RT1, S_RT2, S_EXEC,
        S_CRD, S_CWR, S_POST, S_CALLQ, S_CALLB, S_MUL, S_MULW, S_DONE, S_OUT
    } state_t;

    state_t              state_reg;
    fsmc_pkg::req_t      req_reg;
    fsmc_pkg::op_t       op_reg;
    fsmc_pkg::pc_t       pc_reg;
    fsmc_pkg::sp_t       sp_reg;
    fsmc_pkg::sp_t       rsp_reg;
    fsmc_pkg::cell_t     a_reg;
    logic                stopped_reg;
    fsmc_pkg::cell_t     t_reg;
    fsmc_pkg::cell_t     s_reg;
    fsmc_pkg::cell_t     r_reg;
    fsmc_pkg::cell_t     cell_reg;
    fsmc_pkg::maddr_t    base_reg;
    logic [3:0]          cnt_reg;
    logic [5:0]          mul_cnt_reg;
    fsmc_pkg::fault_t    fault_reg;
    logic [7:0]          rdata_reg;
    logic                sysv_reg;
    fsmc_pkg::cell_t     sysc_reg;
    logic                done_reg;
    fsmc_pkg::result_t   result_reg;

    // Memory and stack port signals.
    logic                mem_we;
    fsmc_pkg::maddr_t    mem_waddr;
    logic [7:0]          mem_wdata;
    fsmc_pkg::maddr_t    mem_raddr;
    logic [7:0]          mem_q;
    logic                ds_we;
    fsmc_pkg::sp_t       ds_waddr;
    fsmc_pkg::cell_t     ds_wdata;
    fsmc_pkg::sp_t       ds_raddr;
    fsmc_pkg::cell_t     ds_q;
    logic                rs_we;
    fsmc_pkg::sp_t       rs_waddr;
    fsmc_pkg::cell_t     rs_wdata;
    fsmc_pkg::cell_t     rs_q;

    fsmc_pkg::alu_op_t   alu_op;
    fsmc_pkg::cell_t     alu_a;
    fsmc_pkg::cell_t     alu_b;
    fsmc_pkg::cell_t     alu_y;

    fsmc_pkg::maddr_t    walk_addr;
    logic                sp_nz;
    logic                sp_two;
    logic                sp_room;
    logic                rsp_room;
    fsmc_pkg::sp_t       sp_pop;

    assign walk_addr = base_reg + fsmc_pkg::maddr_t'(cnt_reg);
    assign sp_nz     = (sp_reg != '0);
    assign sp_two    = (sp_reg >= fsmc_pkg::sp_t'(2));
    assign sp_room   = (sp_reg < fsmc_pkg::SP_FULL);
    assign rsp_room  = (rsp_reg < fsmc_pkg::SP_FULL);
    assign sp_pop    = sp_nz ? (sp_reg - fsmc_pkg::sp_t'(1)) : sp_reg;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    fsmc_ram #(.AW(fsmc_pkg::MEM_AW), .DW(8)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    fsmc_ram #(.AW(fsmc_pkg::STACK_AW), .DW(fsmc_pkg::CELL_W)) u_dstack (
        .clk   (clk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .raddr (ds_raddr),
        .rdata (ds_q)
    );

    fsmc_ram #(.AW(fsmc_pkg::STACK_AW), .DW(fsmc_pkg::CELL_W)) u_rstack (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (rs_wdata),
        .raddr (rsp_reg - fsmc_pkg::sp_t'(1)),
        .rdata (rs_q)
    );

    fsmc_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Cell accesses walk the byte memory one byte a cycle from base_reg; byte
    // writes go to their own address, and only the opcode fetch reads at the pc.
    always_comb
    begin
        mem_raddr = (state_reg == S_FETCH) ? fsmc_pkg::maddr_t'(pc_reg) : walk_addr;
        mem_we    = 1'b0;
        mem_waddr = walk_addr;
        mem_wdata = cell_reg[7:0];
        case (state_reg)
            S_MWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = fsmc_pkg::maddr_t'(req_reg.addr);
                mem_wdata = req_reg.wdata;
            end
            S_CWR:
            begin
                mem_we = 1'b1;
            end
            S_EXEC:
            begin
                mem_we    = (op_reg == fsmc_pkg::OP_CSTA);
                mem_waddr = fsmc_pkg::maddr_t'(a_reg);
                mem_wdata = t_reg[7:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // The top cell is read while the opcode is decoded, the second one
    // right after; the same port reloads the top for the result.
    always_comb
    begin
        ds_raddr = (state_reg == S_RT1) ? (sp_reg - fsmc_pkg::sp_t'(2))
                                        : (sp_reg - fsmc_pkg::sp_t'(1));
        ds_we    = 1'b0;
        ds_waddr = sp_reg;
        ds_wdata = alu_y;
        rs_we    = 1'b0;
        rs_waddr = rsp_reg;
        rs_wdata = t_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (op_reg)
                    fsmc_pkg::OP_COM, fsmc_pkg::OP_SHL, fsmc_pkg::OP_DIV2,
                    fsmc_pkg::OP_DEC, fsmc_pkg::OP_INC:
                    begin
                        ds_we    = sp_nz;
                        ds_waddr = sp_reg - fsmc_pkg::sp_t'(1);
                    end
                    fsmc_pkg::OP_XOR, fsmc_pkg::OP_AND, fsmc_pkg::OP_ADD:
                    begin
                        ds_we    = sp_two;
                        ds_waddr = sp_reg - fsmc_pkg::sp_t'(2);
                    end
                    fsmc_pkg::OP_RFROM:
                    begin
                        ds_we    = sp_room;
                        ds_wdata = r_reg;
                    end
                    fsmc_pkg::OP_AREG:
                    begin
                        ds_we    = sp_room;
                        ds_wdata = a_reg;
                    end
                    fsmc_pkg::OP_DUP:
                    begin
                        ds_we    = sp_room;
                        ds_wdata = t_reg;
                    end
                    fsmc_pkg::OP_OVER:
                    begin
                        ds_we    = sp_room;
                        ds_wdata = s_reg;
                    end
                    fsmc_pkg::OP_TOR:
                    begin
                        rs_we = rsp_room;
                    end
                    default:
                    begin
                        ds_we = 1'b0;
                    end
                endcase
            end
            S_POST:
            begin
                ds_wdata = cell_reg;
                case (op_reg)
                    fsmc_pkg::OP_CFTA, fsmc_pkg::OP_LIT1, fsmc_pkg::OP_FTAP,
                    fsmc_pkg::OP_LIT, fsmc_pkg::OP_FTA:
                    begin
                        ds_we = sp_room;
                    end
                    fsmc_pkg::OP_FETCH:
                    begin
                        ds_we    = sp_nz;
                        ds_waddr = sp_reg - fsmc_pkg::sp_t'(1);
                    end
                    default:
                    begin
                        ds_we = 1'b0;
                    end
                endcase
            end
            S_MULW:
            begin
                ds_we    = sp_two;
                ds_waddr = sp_reg - fsmc_pkg::sp_t'(2);
                ds_wdata = cell_reg;
            end
            S_CALLB:
            begin
                rs_we    = (mem_q != 8'd1) && rsp_room;
                rs_wdata = fsmc_pkg::cell_t'(pc_reg);
            end
            default:
            begin
                ds_we = 1'b0;
            end
        endcase
    end

    // Operand selection for the shared ALU. The multiply loop reuses the
    // adder for each shift-add step.
    always_comb
    begin
        alu_op = fsmc_pkg::ALU_ADD;
        alu_a  = t_reg;
        alu_b  = fsmc_pkg::cell_t'(1);
        if (state_reg == S_MUL)
        begin
            alu_a = cell_reg;
            alu_b = t_reg[0] ? s_reg : '0;
        end
        else
        begin
            case (op_reg)
                fsmc_pkg::OP_COM:  alu_op = fsmc_pkg::ALU_NOT;
                fsmc_pkg::OP_SHL:  alu_op = fsmc_pkg::ALU_SHL;
                fsmc_pkg::OP_DIV2: alu_op = fsmc_pkg::ALU_HALF;
                fsmc_pkg::OP_DEC:  alu_b  = '1;
                fsmc_pkg::OP_XOR:
                begin
                    alu_op = fsmc_pkg::ALU_XOR;
                    alu_a  = s_reg;
                    alu_b  = t_reg;
                end
                fsmc_pkg::OP_AND:
                begin
                    alu_op = fsmc_pkg::ALU_AND;
                    alu_a  = s_reg;
                    alu_b  = t_reg;
                end
                fsmc_pkg::OP_ADD:
                begin
                    alu_a = s_reg;
                    alu_b = t_reg;
                end
                fsmc_pkg::OP_FTAP, fsmc_pkg::OP_STAP:
                begin
                    alu_a = a_reg;
                end
                default:
                begin
                    alu_op = fsmc_pkg::ALU_ADD;
                end
            endcase
        end
    end

    // Sequencer: holds the machine state and the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            sp_reg      <= '0;
            rsp_reg     <= '0;
            a_reg       <= '0;
            stopped_reg <= 1'b1;
            done_reg    <= 1'b0;
            fault_reg   <= fsmc_pkg::FAULT_NONE;
            cnt_reg     <= '0;
            mul_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        req_reg   <= req;
                        rdata_reg <= '0;
                        sysv_reg  <= 1'b0;
                        sysc_reg  <= '0;
                        fault_reg <= fsmc_pkg::FAULT_NONE;
                        cnt_reg   <= '0;
                        base_reg  <= fsmc_pkg::maddr_t'(req.addr);
                        unique case (req.req_type)
                            fsmc_pkg::REQ_WRITE: state_reg <= S_MWR;
                            fsmc_pkg::REQ_READ:  state_reg <= S_BRQ;
                            fsmc_pkg::REQ_SETPC:
                            begin
                                pc_reg      <= fsmc_pkg::wrap_pc(fsmc_pkg::cell_t'(req.addr));
                                stopped_reg <= 1'b0;
                                state_reg   <= S_DONE;
                            end
                            fsmc_pkg::REQ_EXEC:
                            begin
                                state_reg <= stopped_reg ? S_DONE : S_FETCH;
                            end
                        endcase
                    end
                end
                S_MWR:
                begin
                    state_reg <= S_DONE;
                end
                S_BRQ:
                begin
                    state_reg <= S_BRD;
                end
                S_BRD:
                begin
                    if (req_reg.req_type == fsmc_pkg::REQ_READ)
                    begin
                        rdata_reg <= mem_q;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cell_reg  <= fsmc_pkg::cell_t'(mem_q);
                        state_reg <= S_POST;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_FOP;
                end
                S_FOP:
                begin
                    pc_reg <= fsmc_pkg::wrap_pc(fsmc_pkg::cell_t'(pc_reg) + 64'd1);
                    if (mem_q[7:5] != 3'd0)
                    begin
                        fault_reg <= fsmc_pkg::FAULT_OPCODE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        op_reg    <= fsmc_pkg::op_t'(mem_q[4:0]);
                        state_reg <= S_RT1;
                    end
                end
                S_RT1:
                begin
                    t_reg     <= sp_nz ? ds_q : '0;
                    r_reg     <= (rsp_reg != '0) ? rs_q : '0;
                    state_reg <= S_RT2;
                end
                S_RT2:
                begin
                    s_reg     <= sp_two ? ds_q : '0;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DONE;
                    unique case (op_reg)
                        fsmc_pkg::OP_JUMP:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(pc_reg);
                            state_reg <= S_CRD;
                        end
                        fsmc_pkg::OP_RET:
                        begin
                            if (rsp_reg != '0)
                            begin
                                pc_reg  <= fsmc_pkg::wrap_pc(r_reg);
                                rsp_reg <= rsp_reg - fsmc_pkg::sp_t'(1);
                            end
                            else
                            begin
                                stopped_reg <= 1'b1;
                            end
                        end
                        fsmc_pkg::OP_JMPZ, fsmc_pkg::OP_JMPL0:
                        begin
                            if ((op_reg == fsmc_pkg::OP_JMPZ) ? (t_reg == '0) : t_reg[63])
                            begin
                                base_reg  <= fsmc_pkg::maddr_t'(pc_reg);
                                state_reg <= S_CRD;
                            end
                            else
                            begin
                                pc_reg <= fsmc_pkg::wrap_pc(fsmc_pkg::cell_t'(pc_reg) + 64'd8);
                            end
                        end
                        fsmc_pkg::OP_CALL, fsmc_pkg::OP_LIT:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(pc_reg);
                            pc_reg    <= fsmc_pkg::wrap_pc(fsmc_pkg::cell_t'(pc_reg) + 64'd8);
                            state_reg <= S_CRD;
                        end
                        fsmc_pkg::OP_CSTA, fsmc_pkg::OP_XOR, fsmc_pkg::OP_AND,
                        fsmc_pkg::OP_ADD, fsmc_pkg::OP_DROP:
                        begin
                            sp_reg <= sp_pop;
                        end
                        fsmc_pkg::OP_CFTA:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(a_reg);
                            state_reg <= S_BRQ;
                        end
                        fsmc_pkg::OP_SYS:
                        begin
                            sysv_reg <= 1'b1;
                            sysc_reg <= t_reg;
                            sp_reg   <= sp_pop;
                        end
                        fsmc_pkg::OP_LIT1:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(pc_reg);
                            pc_reg    <= fsmc_pkg::wrap_pc(fsmc_pkg::cell_t'(pc_reg) + 64'd1);
                            state_reg <= S_BRQ;
                        end
                        fsmc_pkg::OP_FTAP, fsmc_pkg::OP_FTA:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(a_reg);
                            if (op_reg == fsmc_pkg::OP_FTAP)
                            begin
                                a_reg <= alu_y;
                            end
                            state_reg <= S_CRD;
                        end
                        fsmc_pkg::OP_STORE:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(t_reg);
                            cell_reg  <= s_reg;
                            sp_reg    <= sp_two ? (sp_reg - fsmc_pkg::sp_t'(2)) : '0;
                            state_reg <= S_CWR;
                        end
                        fsmc_pkg::OP_STAP, fsmc_pkg::OP_STA:
                        begin
                            base_reg <= fsmc_pkg::maddr_t'(a_reg);
                            cell_reg <= t_reg;
                            sp_reg   <= sp_pop;
                            if (op_reg == fsmc_pkg::OP_STAP)
                            begin
                                a_reg <= alu_y;
                            end
                            state_reg <= S_CWR;
                        end
                        fsmc_pkg::OP_FETCH:
                        begin
                            base_reg <= fsmc_pkg::maddr_t'(t_reg);
                            if (sp_nz)
                            begin
                                state_reg <= S_CRD;
                            end
                        end
                        fsmc_pkg::OP_COM, fsmc_pkg::OP_SHL, fsmc_pkg::OP_DIV2,
                        fsmc_pkg::OP_DEC, fsmc_pkg::OP_INC:
                        begin
                            state_reg <= S_DONE;
                        end
                        fsmc_pkg::OP_MUL:
                        begin
                            cell_reg    <= '0;
                            mul_cnt_reg <= '0;
                            state_reg   <= S_MUL;
                        end
                        fsmc_pkg::OP_RFROM, fsmc_pkg::OP_AREG, fsmc_pkg::OP_DUP,
                        fsmc_pkg::OP_OVER:
                        begin
                            if ((op_reg == fsmc_pkg::OP_RFROM) && (rsp_reg != '0))
                            begin
                                rsp_reg <= rsp_reg - fsmc_pkg::sp_t'(1);
                            end
                            if (sp_room)
                            begin
                                sp_reg <= sp_reg + fsmc_pkg::sp_t'(1);
                            end
                            else
                            begin
                                fault_reg <= fsmc_pkg::FAULT_DSTACK;
                            end
                        end
                        fsmc_pkg::OP_TOR:
                        begin
                            sp_reg <= sp_pop;
                            if (rsp_room)
                            begin
                                rsp_reg <= rsp_reg + fsmc_pkg::sp_t'(1);
                            end
                            else
                            begin
                                fault_reg <= fsmc_pkg::FAULT_RSTACK;
                            end
                        end
                        fsmc_pkg::OP_TOA:
                        begin
                            a_reg  <= t_reg;
                            sp_reg <= sp_pop;
                        end
                    endcase
                end
                S_CRD:
                begin
                    // Byte k is requested at step k and taken from the registered read port,
                    // filling the cell from the top so it ends little-endian.
                    if (cnt_reg != 4'd0)
                    begin
                        cell_reg <= {mem_q, cell_reg[63:8]};
                    end
                    if (cnt_reg == 4'(fsmc_pkg::CELL_BYTES))
                    begin
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_CWR:
                begin
                    cell_reg <= cell_reg >> 8;
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(fsmc_pkg::CELL_BYTES - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_POST:
                begin
                    state_reg <= S_DONE;
                    case (op_reg)
                        fsmc_pkg::OP_JUMP, fsmc_pkg::OP_JMPZ, fsmc_pkg::OP_JMPL0:
                        begin
                            pc_reg <= fsmc_pkg::wrap_pc(cell_reg);
                        end
                        fsmc_pkg::OP_CALL:
                        begin
                            base_reg  <= fsmc_pkg::maddr_t'(pc_reg);
                            cnt_reg   <= '0;
                            state_reg <= S_CALLQ;
                        end
                        fsmc_pkg::OP_CFTA, fsmc_pkg::OP_LIT1, fsmc_pkg::OP_FTAP,
                        fsmc_pkg::OP_LIT, fsmc_pkg::OP_FTA:
                        begin
                            if (sp_room)
                            begin
                                sp_reg <= sp_reg + fsmc_pkg::sp_t'(1);
                            end
                            else
                            begin
                                fault_reg <= fsmc_pkg::FAULT_DSTACK;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_CALLQ:
                begin
                    state_reg <= S_CALLB;
                end
                S_CALLB:
                begin
                    // A RET right after the operand makes this a tail call.
                    if (mem_q != 8'd1)
                    begin
                        if (rsp_room)
                        begin
                            rsp_reg <= rsp_reg + fsmc_pkg::sp_t'(1);
                        end
                        else
                        begin
                            fault_reg <= fsmc_pkg::FAULT_RSTACK;
                        end
                    end
                    pc_reg    <= fsmc_pkg::wrap_pc(cell_reg);
                    state_reg <= S_DONE;
                end
                S_MUL:
                begin
                    cell_reg    <= alu_y;
                    s_reg       <= s_reg << 1;
                    t_reg       <= t_reg >> 1;
                    mul_cnt_reg <= mul_cnt_reg + 6'd1;
                    if (mul_cnt_reg == '1)
                    begin
                        state_reg <= S_MULW;
                    end
                end
                S_MULW:
                begin
                    sp_reg    <= sp_pop;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (fault_reg != fsmc_pkg::FAULT_NONE)
                    begin
                        stopped_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done_reg                <= 1'b1;
                    result_reg.rdata        <= rdata_reg;
                    result_reg.pc_now       <= pc_reg;
                    result_reg.top_of_stack <= sp_nz ? ds_q : '0;
                    result_reg.stack_depth  <= 6'(sp_reg);
                    result_reg.halted       <= stopped_reg;
                    result_reg.sys_valid    <= sysv_reg;
                    result_reg.sys_code     <= sysc_reg;
                    result_reg.fault        <= fault_reg;
                    state_reg               <= S_IDLE;
                end
            endcase
        end
    end

    // A taken request always makes the block busy in the next cycle.
    `ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
    // A result is only shown once the sequencer is back to idle.
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    // Any fault stops the machine by the time its result is shown.
    `ASSERT_SAME(a_fault_halts, clk, rst_n,
        done && (result.fault != fsmc_pkg::FAULT_NONE), result.halted)
    // SYS never pushes, so it cannot report a fault in the same step.
    `ASSERT_SAME(a_sys_clean, clk, rst_n,
        done && result.sys_valid, result.fault == fsmc_pkg::FAULT_NONE)

endmodule

// File: rtl/core/fsmc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the byte memory and both stacks.
module fsmc_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    localparam int DEPTH = 2 ** AW;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/fsmc_alu.sv
// Shared 64-bit arithmetic and logic unit of the core.
// Depends on fsmc_pkg for the operation codes and cell type.
module fsmc_alu (
    input  fsmc_pkg::alu_op_t op,
    input  fsmc_pkg::cell_t   a,
    input  fsmc_pkg::cell_t   b,
    output fsmc_pkg::cell_t   y
);

    fsmc_pkg::cell_t mag;

    // Halving toward zero works on the magnitude and restores the sign.
    assign mag = a[63] ? (~a + fsmc_pkg::cell_t'(1)) : a;

    always_comb
    begin
        case (op)
            fsmc_pkg::ALU_ADD:  y = a + b;
            fsmc_pkg::ALU_XOR:  y = a ^ b;
            fsmc_pkg::ALU_AND:  y = a & b;
            fsmc_pkg::ALU_NOT:  y = ~a;
            fsmc_pkg::ALU_SHL:  y = {a[62:0], 1'b0};
            fsmc_pkg::ALU_HALF: y = a[63] ? (~(mag >> 1) + fsmc_pkg::cell_t'(1)) : (a >> 1);
            default:            y = a;
        endcase
    end

endmodule
